>>> rtl/tle_pkg.sv
// Package for the EUC_2D tour length block: widths, limits, state types,
// the request and response structs of the edge unit, and the saturating add.
// No dependencies.
`default_nettype none

package tle_pkg;

  localparam int unsigned COORD_W   = 15;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned SUM_W     = 33;
  localparam int unsigned SQ_W      = 31;   // dx*dx+dy*dy < 2^31
  localparam int unsigned MAX_CITIES = 131072;
  localparam int unsigned EDGE_MAX  = 46340;
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(64'(MAX_CITIES) * 64'(EDGE_MAX));

  // Top-level sequencer
  typedef enum logic [1:0] {
    T_IDLE,
    T_EDGE,
    T_CLOSE,
    T_WRITE
  } tour_state_t;

  // Edge unit sequencer
  typedef enum logic [2:0] {
    E_IDLE,
    E_SQX,
    E_SQY,
    E_ROOT,
    E_ROUND
  } edge_state_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } tle_edge_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] len;
  } tle_edge_rsp_t;

  // Add an edge to the sum, clamp at SUM_MAX
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, a} + (SUM_W+1)'(b);
    return (t > {1'b0, SUM_MAX}) ? SUM_MAX : t[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tle_city_if.sv
// Input channel of the tour length block: one city per transfer.
// Depends on tle_pkg.
`default_nettype none

interface tle_city_if import tle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] city_x;
  logic [COORD_W-1:0] city_y;
  logic               last_city;

  modport source (output valid, output city_x, output city_y, output last_city,
                  input ready);
  modport sink   (input valid, input city_x, input city_y, input last_city,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/tle_result_if.sv
// Output channel of the tour length block: one result per transfer.
// Depends on tle_pkg.
`default_nettype none

interface tle_result_if import tle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] edge_length;
  logic [LEN_W-1:0] closing_length;
  logic [SUM_W-1:0] tour_length;
  logic             tour_done;

  modport source (output valid, output edge_length, output closing_length,
                  output tour_length, output tour_done, input ready);
  modport sink   (input valid, input edge_length, input closing_length,
                  input tour_length, input tour_done, output ready);
endinterface

`default_nettype wire

>>> rtl/tle_edge.sv
// Edge unit: rounded Euclidean distance between two points, computed with
// one shared squarer and a bit-pair integer square root. Depends on tle_pkg.
`default_nettype none

module tle_edge import tle_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  tle_edge_req_t req,
  output tle_edge_rsp_t rsp
);

  edge_state_t state, state_next;

  logic [COORD_W-1:0]   dx;
  logic [COORD_W-1:0]   dy;
  logic [SQ_W-1:0]      rem;
  logic [SQ_W-1:0]      root;
  logic [SQ_W-1:0]      bitv;
  logic [COORD_W-1:0]   mul_op;
  logic [2*COORD_W-1:0] prod;
  logic [SQ_W:0]        trial;
  logic                 can_start;

  assign can_start = (state == E_IDLE) || (state == E_ROUND);

  // Shared squarer: dx in the first pass, dy in the second
  assign mul_op = (state == E_SQX) ? dx : dy;
  assign prod   = mul_op * mul_op;
  assign trial  = {1'b0, root} + {1'b0, bitv};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      E_IDLE:  if (req.start) state_next = E_SQX;
      E_SQX:   state_next = E_SQY;
      E_SQY:   state_next = E_ROOT;
      E_ROOT:  if (bitv[0]) state_next = E_ROUND;
      E_ROUND: state_next = req.start ? E_SQX : E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  // Outputs: round half up, rem holds s - r*r after the root
  always_comb begin
    rsp.done = (state == E_ROUND);
    rsp.len  = root[LEN_W-1:0] + LEN_W'(rem > root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      E_SQX: begin
        rem <= SQ_W'(prod);
      end
      E_SQY: begin
        rem  <= rem + SQ_W'(prod);
        root <= '0;
        bitv <= SQ_W'(1) << (SQ_W - 1);
      end
      E_ROOT: begin
        // Take one result bit per step
        if ({1'b0, rem} >= trial) begin
          rem  <= rem - trial[SQ_W-1:0];
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      default: ;
    endcase
    if (can_start && req.start) begin
      dx <= (req.ax > req.bx) ? req.ax - req.bx : req.bx - req.ax;
      dy <= (req.ay > req.by) ? req.ay - req.by : req.by - req.ay;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tour_length_euc2d.sv
// Tour length block: controller, tour state, running sum and result register.
// Depends on tle_pkg, tle_city_if, tle_result_if and tle_edge.
//
// Usage: cities of a closed tour arrive in tour order on the city channel,
// the final one flagged by last_city. Every city gives one transfer on the
// result channel: edge_length from the previous city (0 for a tour's first
// city); on the final city also closing_length back to the first city, the
// saturating tour_length and tour_done. After the final city the block
// starts a fresh tour.
// Sequencing: the edge unit squares dx and dy on its one multiplier, then
// takes 16 square-root steps of one bit each and a rounding step. On the
// final city the closing edge follows the city's own edge; the first city
// of a tour needs no edge. city.ready is high only while the controller is
// idle, so a new city is taken only after the last one has been written.
// Reset (rst, synchronous) clears the tour and empties the result register.
// A stalled receiver holds the result register; the block still takes and
// works on the next city, and waits only to write its result.
`default_nettype none

module tour_length_euc2d import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tle_city_if.sink   city,
  tle_result_if.source result
);

  tour_state_t state, state_next;

  tle_edge_req_t edge_req;
  tle_edge_rsp_t edge_rsp;

  logic [COORD_W-1:0] first_x, first_y;
  logic [COORD_W-1:0] prev_x, prev_y;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic               cur_last;
  logic               tour_started;
  logic [SUM_W-1:0]   running_sum;
  logic [LEN_W-1:0]   edge_len;
  logic [LEN_W-1:0]   close_len;
  logic [SUM_W-1:0]   total;
  logic               take;
  logic               out_free;

  assign take     = city.valid && city.ready;
  assign out_free = !result.valid || result.ready;

  tle_edge u_edge (
    .clk (clk),
    .rst (rst),
    .req (edge_req),
    .rsp (edge_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:  if (take) state_next = tour_started ? T_EDGE : T_WRITE;
      T_EDGE:  if (edge_rsp.done) state_next = cur_last ? T_CLOSE : T_WRITE;
      T_CLOSE: if (edge_rsp.done) state_next = T_WRITE;
      T_WRITE: if (out_free) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Outputs: ready and edge unit requests
  always_comb begin
    city.ready     = (state == T_IDLE);
    edge_req.start = 1'b0;
    edge_req.ax    = prev_x;
    edge_req.ay    = prev_y;
    edge_req.bx    = city.city_x;
    edge_req.by    = city.city_y;
    case (state)
      T_IDLE: begin
        edge_req.start = take && tour_started;
      end
      T_EDGE: begin
        edge_req.start = edge_rsp.done && cur_last;
        edge_req.ax    = cur_x;
        edge_req.ay    = cur_y;
        edge_req.bx    = first_x;
        edge_req.by    = first_y;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      tour_started <= 1'b0;
      running_sum  <= '0;
      first_x      <= '0;
      first_y      <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      // Load a new result or drop the one just transferred
      if ((state == T_WRITE) && out_free) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          // Open a tour on its first city
          if (take && !tour_started) begin
            first_x      <= city.city_x;
            first_y      <= city.city_y;
            running_sum  <= '0;
            tour_started <= 1'b1;
          end
        end
        T_EDGE: begin
          if (edge_rsp.done) begin
            running_sum <= sat_add(running_sum, edge_rsp.len);
          end
        end
        T_WRITE: begin
          // Advance the tour and drop it after its final city
          if (out_free) begin
            prev_x       <= cur_x;
            prev_y       <= cur_y;
            if (cur_last) begin
              tour_started <= 1'b0;
              running_sum  <= '0;
              first_x      <= '0;
              first_y      <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        if (take) begin
          cur_x     <= city.city_x;
          cur_y     <= city.city_y;
          cur_last  <= city.last_city;
          edge_len  <= '0;
          close_len <= '0;
          total     <= '0;
        end
      end
      T_EDGE: begin
        if (edge_rsp.done) begin
          edge_len <= edge_rsp.len;
        end
      end
      T_CLOSE: begin
        if (edge_rsp.done) begin
          close_len <= edge_rsp.len;
          total     <= sat_add(running_sum, edge_rsp.len);
        end
      end
      T_WRITE: begin
        if (out_free) begin
          result.edge_length    <= edge_len;
          result.closing_length <= cur_last ? close_len : '0;
          result.tour_length    <= cur_last ? total : '0;
          result.tour_done      <= cur_last;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> tb/tour_length_euc2d_checker.sv
// Checker for the EUC_2D tour length block: watches both channels, predicts
// every result from the accepted cities and compares field by field.
// Depends on tle_pkg, tle_city_if and tle_result_if.
`timescale 1ns / 100ps

module tour_length_euc2d_checker import tle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tle_city_if         city,
  tle_result_if       result,
  output int unsigned fail_count,
  output int unsigned due_count
);

  typedef struct packed {
    logic [LEN_W-1:0] edge_len;
    logic [LEN_W-1:0] closing_len;
    logic [SUM_W-1:0] tour_len;
    logic             done;
  } length_result_t;

  // Tour state of the predictor
  logic [COORD_W-1:0] start_x, start_y;
  logic [COORD_W-1:0] last_x, last_y;
  logic               in_tour;
  logic [SUM_W-1:0]   length_so_far;

  length_result_t lengths_due[$];
  int unsigned    results_seen;

  // Largest r with r*r <= s, one result bit per trial from the top down
  function automatic logic [LEN_W-1:0] root_floor(input logic [SQ_W-1:0] s);
    logic [LEN_W-1:0] r;
    logic [LEN_W-1:0] trial;
    r = '0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      trial = r | (LEN_W'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(s)) r = trial;
    end
    return r;
  endfunction

  // Rounded distance: round up when s lies above (r + 1/2)^2, i.e. s > r*r + r
  function automatic logic [LEN_W-1:0] euc2d_length(
    input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
    input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by);
    logic [COORD_W-1:0] dx, dy;
    logic [SQ_W-1:0]    s;
    logic [LEN_W-1:0]   r;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    s  = SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
    r  = root_floor(s);
    if (64'(s) > 64'(r) * 64'(r) + 64'(r)) r = r + 1'b1;
    return r;
  endfunction

  // Add one edge, clamp at the sum ceiling
  function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] acc,
                                                   input logic [LEN_W-1:0] len);
    logic [SUM_W:0] wide;
    wide = (SUM_W+1)'(acc) + (SUM_W+1)'(len);
    if (wide > (SUM_W+1)'(SUM_MAX)) return SUM_MAX;
    return wide[SUM_W-1:0];
  endfunction

  task automatic clear_tour();
    start_x = '0;
    start_y = '0;
    last_x = '0;
    last_y = '0;
    in_tour = 1'b0;
    length_so_far = '0;
  endtask

  // Advance the tour by one city and queue the result it causes
  task automatic predict_city(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic is_last);
    length_result_t r;
    r = '0;
    if (!in_tour) begin
      start_x = x;
      start_y = y;
      length_so_far = '0;
      in_tour = 1'b1;
    end else begin
      r.edge_len = euc2d_length(last_x, last_y, x, y);
      length_so_far = add_clamped(length_so_far, r.edge_len);
    end
    last_x = x;
    last_y = y;
    if (is_last) begin
      r.closing_len = euc2d_length(x, y, start_x, start_y);
      r.tour_len = add_clamped(length_so_far, r.closing_len);
      r.done = 1'b1;
      clear_tour();
    end
    lengths_due.push_back(r);
  endtask

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: result %0d: %s got %0d, want %0d",
             $time, results_seen, what, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    length_result_t want;
    results_seen++;
    if (lengths_due.size() == 0) begin
      report_mismatch("unexpected transfer, tour_length", result.tour_length, 0);
    end else begin
      want = lengths_due.pop_front();
      if (result.edge_length !== want.edge_len)
        report_mismatch("edge_length", result.edge_length, want.edge_len);
      if (result.closing_length !== want.closing_len)
        report_mismatch("closing_length", result.closing_length, want.closing_len);
      if (result.tour_length !== want.tour_len)
        report_mismatch("tour_length", result.tour_length, want.tour_len);
      if (result.tour_done !== want.done)
        report_mismatch("tour_done", result.tour_done, want.done);
    end
  endtask

  // Watch both channels on every rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_tour();
      lengths_due.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (city.valid && city.ready)
        predict_city(city.city_x, city.city_y, city.last_city);
      if (result.valid && result.ready)
        check_result();
    end
    due_count = lengths_due.size();
  end

endmodule

>>> tb/tour_length_euc2d_tb.sv
// Testbench top for the EUC_2D tour length block: clock, reset, city stimulus,
// result back-pressure, watchdog and verdict.
// Depends on tle_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 100ps

module tour_length_euc2d_tb;
  import tle_pkg::*;

  localparam int unsigned CITY_COUNT  = 1150;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CALM_FROM   = 700;
  localparam int unsigned CALM_TO     = 850;
  localparam logic [COORD_W-1:0] COORD_TOP = '1;

  typedef enum int {
    SPREAD,
    WALK_NEAR,
    CORNERS,
    WALK_FAR
  } city_pattern_t;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned mismatches;
  int unsigned results_due;
  int unsigned cities_sent = 0;
  logic        calm = 1'b0;

  tle_city_if   city_ch();
  tle_result_if result_ch();

  tour_length_euc2d u_top (
    .clk    (clk),
    .rst    (rst),
    .city   (city_ch),
    .result (result_ch)
  );

  tour_length_euc2d_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .city       (city_ch),
    .result     (result_ch),
    .fail_count (mismatches),
    .due_count  (results_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one city, hold it until the transfer
  task automatic send_city(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic is_last);
    int unsigned gap;
    calm = (cities_sent >= CALM_FROM) && (cities_sent < CALM_TO);
    if (!calm && $urandom_range(99) < 25) begin
      gap = $urandom_range(20, 1);
      city_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    city_ch.valid     <= 1'b1;
    city_ch.city_x    <= x;
    city_ch.city_y    <= y;
    city_ch.last_city <= is_last;
    do @(posedge clk); while (!city_ch.ready);
    cities_sent++;
  endtask

  // Next coordinate of a tour in the given pattern
  function automatic logic [COORD_W-1:0] next_coord(input city_pattern_t pattern,
                                                    input logic [COORD_W-1:0] c);
    int v;
    case (pattern)
      SPREAD:    return COORD_W'($urandom);
      WALK_NEAR: v = int'(c) + int'($urandom_range(80)) - 40;
      CORNERS: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return COORD_TOP;
          default: return COORD_W'($urandom);
        endcase
      end
      default:   v = int'(c) + int'($urandom_range(4000)) - 2000;
    endcase
    if (v < 0) v = 0;
    if (v > int'(COORD_TOP)) v = int'(COORD_TOP);
    return COORD_W'(v);
  endfunction

  // Stimulus: reset, directed tours, random tours, drain, verdict
  initial begin
    int unsigned   pick;
    int unsigned   tour_cities;
    city_pattern_t pattern;
    logic [COORD_W-1:0] x, y;

    rst <= 1'b1;
    city_ch.valid     <= 1'b0;
    city_ch.city_x    <= '0;
    city_ch.city_y    <= '0;
    city_ch.last_city <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Single-city tours at both corners
    send_city('0, '0, 1'b1);
    send_city(COORD_TOP, COORD_TOP, 1'b1);
    // Longest diagonal, then back along one side; then the other diagonal
    send_city('0, '0, 1'b0);
    send_city(COORD_TOP, COORD_TOP, 1'b0);
    send_city('0, COORD_TOP, 1'b1);
    send_city(COORD_TOP, '0, 1'b0);
    send_city('0, COORD_TOP, 1'b1);
    // Coincident cities
    send_city(15'd100, 15'd100, 1'b0);
    send_city(15'd100, 15'd100, 1'b1);
    // Round down (sqrt 2) and round up (sqrt 13)
    send_city('0, '0, 1'b0);
    send_city(15'd1, 15'd1, 1'b0);
    send_city(15'd4, 15'd3, 1'b0);
    send_city(15'd1, 15'd1, 1'b1);
    // Alternating bit patterns
    send_city(15'h5555, 15'h2AAA, 1'b0);
    send_city(15'h2AAA, 15'h5555, 1'b0);
    send_city(COORD_TOP, '0, 1'b1);

    // Random tours, mostly short
    while (cities_sent < CITY_COUNT) begin
      pick = $urandom_range(99);
      if (pick < 5)       tour_cities = 1;
      else if (pick < 85) tour_cities = $urandom_range(12, 2);
      else if (pick < 97) tour_cities = $urandom_range(40, 13);
      else                tour_cities = $urandom_range(120, 41);
      pattern = city_pattern_t'($urandom_range(3));
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      for (int i = 0; i < tour_cities; i++) begin
        if (i > 0) begin
          x = next_coord(pattern, x);
          y = next_coord(pattern, y);
        end
        send_city(x, y, i == tour_cities - 1);
      end
    end
    city_ch.valid <= 1'b0;

    // Drain, then let stray transfers show up
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if ((mismatches == 0) && (results_due == 0)) begin
      $display("[tour_length_euc2d] OK");
    end else begin
      $display("[tour_length_euc2d] ERROR");
    end
    $finish;
  end

  // Result back-pressure, with one long hold-off while cities keep coming
  initial begin
    bit held = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && cities_sent >= HOLD_AT) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_ch.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin
    int unsigned quiet = 0;
    forever begin
      @(posedge clk);
      if ((city_ch.valid && city_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[tour_length_euc2d] ERROR");
        $finish;
      end
    end
  end

endmodule

>>> tour_length_euc2d.f
rtl/tle_pkg.sv
rtl/tle_city_if.sv
rtl/tle_result_if.sv
rtl/tle_edge.sv
rtl/tour_length_euc2d.sv
tb/tour_length_euc2d_checker.sv
tb/tour_length_euc2d_tb.sv
